/* sv/acs_pkg.sv */
package acs_pkg;

  // default geometry
  localparam int CHANNELS_DEF      = 64;
  localparam int MODULE_OFFSET_DEF = 32;
  localparam int SAMPLE_BITS_DEF   = 12;
  localparam int FRAC_BITS_DEF     = 8;

  // fixed field widths
  localparam int SAMPLE_CH_W = 6;
  localparam int READ_CH_W   = 8;
  localparam int ID_W        = 9;   // holds channel + offset and the channel count
  localparam int CNT_W       = 32;
  localparam int SHIFT_W     = 3;
  localparam logic [SHIFT_W-1:0] SHIFT_RESET = 3'd3;

  // register port
  localparam int APB_AW    = 3;
  localparam int APB_DW    = 32;
  localparam int REG_IDX_W = 1;
  localparam logic [REG_IDX_W-1:0] REG_FILTER_SHIFT = 1'b0;

  // request codes
  typedef enum logic [1:0] {
    REQ_SAMPLE = 2'd0,
    REQ_READ   = 2'd1,
    REQ_EOC    = 2'd2
  } req_type_t;

endpackage

/* sv/acs_ifs.sv */
// request channel: sample, read or end-of-conversion
interface acs_req_if import acs_pkg::*; #(
  parameter int SAMPLE_BITS = SAMPLE_BITS_DEF
) ();
  logic                   valid;
  logic                   ready;
  logic [1:0]             req_type;
  logic                   adc_module;
  logic [SAMPLE_CH_W-1:0] sample_channel;
  logic [SAMPLE_BITS-1:0] sample_value;
  logic [READ_CH_W-1:0]   read_channel;

  modport source (output valid, req_type, adc_module, sample_channel, sample_value,
                  read_channel, input ready);
  modport sink   (input valid, req_type, adc_module, sample_channel, sample_value,
                  read_channel, output ready);
endinterface

// result channel: answers to read requests
interface acs_rsp_if import acs_pkg::*; #(
  parameter int SAMPLE_BITS = SAMPLE_BITS_DEF,
  parameter int FRAC_BITS   = FRAC_BITS_DEF
) ();
  logic                             valid;
  logic                             ready;
  logic [SAMPLE_BITS-1:0]           raw_value;
  logic [SAMPLE_BITS+FRAC_BITS-1:0] filtered_value;
  logic                             new_flag;
  logic [CNT_W-1:0]                 conversion_count;
  logic                             range_error;

  modport source (output valid, raw_value, filtered_value, new_flag, conversion_count,
                  range_error, input ready);
  modport sink   (input valid, raw_value, filtered_value, new_flag, conversion_count,
                  range_error, output ready);
endinterface

/* sv/acs_ram.sv */
module acs_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 64
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  // one write port, one registered read port (old data on collision)
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

/* sv/acs_apb_regs.sv */
module acs_apb_regs import acs_pkg::*; (
  input  logic               clk,
  input  logic               rst,
  input  logic               psel,
  input  logic               penable,
  input  logic               pwrite,
  input  logic [APB_AW-1:0]  paddr,
  input  logic [APB_DW-1:0]  pwdata,
  output logic [APB_DW-1:0]  prdata,
  output logic               pready,
  output logic [SHIFT_W-1:0] filter_shift
);

  logic [REG_IDX_W-1:0] reg_idx;
  logic                 wr_en;

  assign reg_idx = paddr[APB_AW-1:2];
  assign wr_en   = psel && penable && pwrite;
  assign pready  = 1'b1;

  // register write
  always_ff @(posedge clk) begin
    if (rst) begin
      filter_shift <= SHIFT_RESET;
    end else if (wr_en && reg_idx == REG_FILTER_SHIFT) begin
      filter_shift <= pwdata[SHIFT_W-1:0];
    end
  end

  // read mux
  always_comb begin
    prdata = '0;
    unique case (reg_idx)
      REG_FILTER_SHIFT: prdata = APB_DW'(filter_shift);
      default:          prdata = '0;
    endcase
  end

endmodule

/* sv/acs_ema.sv */
module acs_ema import acs_pkg::*; #(
  parameter int SAMPLE_BITS = SAMPLE_BITS_DEF,
  parameter int FRAC_BITS   = FRAC_BITS_DEF
) (
  input  logic [SAMPLE_BITS+FRAC_BITS-1:0] f_old,
  input  logic [SAMPLE_BITS-1:0]           x,
  input  logic [SHIFT_W-1:0]               shift,
  output logic [SAMPLE_BITS+FRAC_BITS-1:0] f_new
);

  localparam int FW = SAMPLE_BITS + FRAC_BITS;

  logic [FW-1:0]        target;
  logic signed [FW:0]   diff;
  logic signed [FW:0]   step;

  // f += (target - f) >>> shift; the step rounds toward minus infinity
  assign target = {x, {FRAC_BITS{1'b0}}};
  assign diff   = $signed({1'b0, target}) - $signed({1'b0, f_old});
  assign step   = diff >>> shift;
  assign f_new  = f_old + step[FW-1:0];

endmodule

/* sv/adc_channel_ema_store.sv */
// Per-channel ADC result store with an exponential moving average filter.
// Requests come in on req (valid/ready): a sample writes the raw value and
// updates the filter of channel sample_channel (+MODULE_OFFSET for converter
// 1), an end-of-conversion bumps a 32-bit wrapping counter, and a read
// returns raw value, Q.FRAC_BITS filtered value, new flag and counter on rsp.
// Reads above the last channel return zero data with range_error set.
// Samples to a channel past the store are dropped.
// A read request passes the store's registered read and the filter stage,
// then the result register. Throughput is one request per cycle while
// req.ready is high, including back-to-back samples to the same channel,
// which are forwarded around the store's write. The filter weight register
// (filter_shift, APB address 0) must be written only while no request is
// in flight; the block does not enforce this. Reset clears all new flags
// (an unflagged channel reads as zero), the counter, and sets filter_shift
// to 3; no clearing pass runs, requests are taken from the first cycle after
// reset. When rsp stalls with a result pending, a read in the filter stage
// waits and req.ready drops for all requests; only a read stalls there.
module adc_channel_ema_store import acs_pkg::*; #(
  parameter int CHANNELS      = CHANNELS_DEF,
  parameter int MODULE_OFFSET = MODULE_OFFSET_DEF,
  parameter int SAMPLE_BITS   = SAMPLE_BITS_DEF,
  parameter int FRAC_BITS     = FRAC_BITS_DEF
) (
  input  logic              clk,
  input  logic              rst,
  acs_req_if.sink           req,
  acs_rsp_if.source         rsp,
  input  logic              psel,
  input  logic              penable,
  input  logic              pwrite,
  input  logic [APB_AW-1:0] paddr,
  input  logic [APB_DW-1:0] pwdata,
  output logic [APB_DW-1:0] prdata,
  output logic              pready
);

  localparam int FW = SAMPLE_BITS + FRAC_BITS;
  localparam int AW = $clog2(CHANNELS);
  localparam int EW = SAMPLE_BITS + FW;

  logic [SHIFT_W-1:0] filter_shift;

  acs_apb_regs u_regs (
    .clk          (clk),
    .rst          (rst),
    .psel         (psel),
    .penable      (penable),
    .pwrite       (pwrite),
    .paddr        (paddr),
    .pwdata       (pwdata),
    .prdata       (prdata),
    .pready       (pready),
    .filter_shift (filter_shift)
  );

  // ---------------- request decode and store read ----------------
  logic            accept;
  logic [ID_W-1:0] sample_id;
  logic [ID_W-1:0] sel_id;
  logic            sel_in_range;

  assign accept    = req.valid && req.ready;
  assign sample_id = ID_W'(req.sample_channel)
                   + (req.adc_module ? ID_W'(MODULE_OFFSET) : ID_W'(0));
  assign sel_id    = (req.req_type == REQ_READ) ? ID_W'(req.read_channel) : sample_id;
  assign sel_in_range = sel_id < ID_W'(CHANNELS);

  // filter stage registers
  logic                   s1_valid;
  logic [1:0]             s1_type;
  logic [AW-1:0]          s1_addr;
  logic                   s1_in_range;
  logic [SAMPLE_BITS-1:0] s1_sample;
  logic                   s1_adv;
  logic                   s1_write;

  logic [EW-1:0]          ram_rdata;
  logic [EW-1:0]          ram_wdata;

  // forward of the last write, which the store read could not see yet
  logic                   wr_valid_q;
  logic [AW-1:0]          wr_addr_q;
  logic [EW-1:0]          wr_data_q;

  logic [CHANNELS-1:0]    new_flags;
  logic [CNT_W-1:0]       conversion_cnt;

  acs_ram #(
    .WIDTH (EW),
    .DEPTH (CHANNELS)
  ) u_store (
    .clk   (clk),
    .we    (s1_write),
    .waddr (s1_addr),
    .wdata (ram_wdata),
    .re    (accept),
    .raddr (sel_id[AW-1:0]),
    .rdata (ram_rdata)
  );

  // ---------------- filter stage ----------------
  logic [EW-1:0]          entry;
  logic                   entry_flag;
  logic [SAMPLE_BITS-1:0] old_raw;
  logic [FW-1:0]          old_filt;
  logic [FW-1:0]          new_filt;

  assign entry_flag = new_flags[s1_addr];

  // pick forwarded data, and treat never-written channels as zero
  always_comb begin
    entry = ram_rdata;
    if (wr_valid_q && wr_addr_q == s1_addr) begin
      entry = wr_data_q;
    end
    if (!entry_flag) begin
      entry = '0;
    end
  end

  assign old_raw  = entry[EW-1:FW];
  assign old_filt = entry[FW-1:0];

  acs_ema #(
    .SAMPLE_BITS (SAMPLE_BITS),
    .FRAC_BITS   (FRAC_BITS)
  ) u_ema (
    .f_old (old_filt),
    .x     (s1_sample),
    .shift (filter_shift),
    .f_new (new_filt)
  );

  assign ram_wdata = {s1_sample, new_filt};
  assign s1_write  = s1_valid && s1_type == REQ_SAMPLE && s1_in_range;
  // only a read waits, and only on a full, stalled result register
  assign s1_adv    = !(s1_valid && s1_type == REQ_READ && rsp.valid && !rsp.ready);
  assign req.ready = s1_adv;

  // stage control
  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid   <= 1'b0;
      wr_valid_q <= 1'b0;
    end else if (s1_adv) begin
      s1_valid   <= accept;
      wr_valid_q <= s1_write;
    end
  end

  // stage payload
  always_ff @(posedge clk) begin
    if (accept) begin
      s1_type     <= req.req_type;
      s1_addr     <= sel_id[AW-1:0];
      s1_in_range <= sel_in_range;
      s1_sample   <= req.sample_value;
    end
    if (s1_adv) begin
      wr_addr_q <= s1_addr;
      wr_data_q <= ram_wdata;
    end
  end

  // new flags and event counter
  always_ff @(posedge clk) begin
    if (rst) begin
      new_flags      <= '0;
      conversion_cnt <= '0;
    end else begin
      if (s1_write) begin
        new_flags[s1_addr] <= 1'b1;
      end
      if (s1_valid && s1_type == REQ_EOC) begin
        conversion_cnt <= conversion_cnt + CNT_W'(1);
      end
    end
  end

  // ---------------- result register ----------------
  logic load_rsp;

  assign load_rsp = s1_valid && s1_type == REQ_READ && s1_adv;

  always_ff @(posedge clk) begin
    if (rst) begin
      rsp.valid <= 1'b0;
    end else if (load_rsp) begin
      rsp.valid <= 1'b1;
    end else if (rsp.ready) begin
      rsp.valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (load_rsp) begin
      rsp.raw_value        <= s1_in_range ? old_raw : '0;
      rsp.filtered_value   <= s1_in_range ? old_filt : '0;
      rsp.new_flag         <= s1_in_range && entry_flag;
      rsp.conversion_count <= conversion_cnt;
      rsp.range_error      <= !s1_in_range;
    end
  end

  // ---------------- checks ----------------
  a_range_zero: assert property (@(posedge clk) disable iff (rst)
    (rsp.valid && rsp.range_error) |->
      (rsp.raw_value == '0 && rsp.filtered_value == '0 && !rsp.new_flag))
    else $error("range error result carries data");

  a_flag_set: assert property (@(posedge clk) disable iff (rst)
    s1_write |=> new_flags[$past(s1_addr)])
    else $error("new flag not set after sample write");

  a_cnt_step: assert property (@(posedge clk) disable iff (rst)
    (s1_valid && s1_type == REQ_EOC) |=>
      (conversion_cnt == $past(conversion_cnt) + CNT_W'(1)))
    else $error("conversion counter missed an event");

  a_stall_hold: assert property (@(posedge clk) disable iff (rst)
    (s1_valid && !s1_adv) |=> (s1_valid && $stable(s1_addr) && $stable(ram_rdata)))
    else $error("stalled read lost its store data");

endmodule
